/* rtl/php_pkg.sv */
package php_pkg;

    localparam int  DATA_W    = 208;
    localparam int  STATUS_W  = 3;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_START  = 3'd1;
    localparam logic [2:0] ST_BAD_MARKER = 3'd2;
    localparam logic [2:0] ST_BAD_TS     = 3'd3;
    localparam logic [2:0] ST_TRUNC      = 3'd4;

    localparam logic [5:0] POS_SC0    = 6'd0;
    localparam logic [5:0] POS_SC1    = 6'd1;
    localparam logic [5:0] POS_SC2    = 6'd2;
    localparam logic [5:0] POS_ID     = 6'd3;
    localparam logic [5:0] POS_LEN_HI = 6'd4;
    localparam logic [5:0] POS_LEN_LO = 6'd5;
    localparam logic [5:0] POS_FLAG1  = 6'd6;
    localparam logic [5:0] POS_FLAG2  = 6'd7;
    localparam logic [5:0] POS_HLEN   = 6'd8;
    localparam logic [5:0] POS_OPT    = 6'd9;

    localparam logic [2:0] FLD_NONE  = 3'd0;
    localparam logic [2:0] FLD_PTS   = 3'd1;
    localparam logic [2:0] FLD_DTS   = 3'd2;
    localparam logic [2:0] FLD_ESCR  = 3'd3;
    localparam logic [2:0] FLD_RATE  = 3'd4;
    localparam logic [2:0] FLD_TRICK = 3'd5;
    localparam logic [2:0] FLD_COPY  = 3'd6;
    localparam logic [2:0] FLD_CRC   = 3'd7;

    localparam int NUM_FIELDS = 7;
    localparam logic [5:0] FIELD_SIZE [NUM_FIELDS] = '{
        6'd5, 6'd5, 6'd6, 6'd3, 6'd1, 6'd1, 6'd2
    };

    localparam logic [8:0] HEADER_FIXED = 9'd9;

    typedef struct packed {
        logic        active;
        logic [5:0]  pos;
        logic        sc_err;
        logic [7:0]  pes_sid;
        logic [15:0] length;
        logic [13:0] flags;
        logic [7:0]  header_len;
        logic [32:0] pts;
        logic [32:0] dts;
        logic [32:0] ref_clk_base;
        logic [8:0]  ref_clk_ext;
        logic [21:0] rate;
        logic [9:0]  trick_copy;
        logic [15:0] crc;
    } t_state;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  pes_sid;
        logic [15:0] packet_length;
        logic [13:0] header_flags;
        logic [32:0] pts;
        logic [32:0] dts;
        logic [32:0] ref_clk_base;
        logic [8:0]  ref_clk_ext;
        logic [21:0] es_rate;
        logic [9:0]  trick_and_copy;
        logic [15:0] previous_crc;
        logic [8:0]  header_size;
    } t_result;

    typedef struct packed {
        logic [2:0] id;
        logic [2:0] off;
        logic [5:0] last;
    } t_loc;

    function automatic t_loc locate(input logic [5:0] p, input logic [7:0] f2);
        t_loc       l;
        logic [5:0] pos;
        l   = '0;
        pos = POS_OPT;
        for (int k = 0; k < NUM_FIELDS; k++) begin
            if (f2[7-k]) begin
                if (l.id == FLD_NONE && p >= pos && p < pos + FIELD_SIZE[k]) begin
                    l.id  = 3'(k + 1);
                    l.off = 3'(p - pos);
                end
                pos = pos + FIELD_SIZE[k];
            end
        end
        l.last = pos;
        return l;
    endfunction

    function automatic logic [32:0] ts_shift(input logic [32:0] r, input logic [2:0] off,
                                             input logic [7:0] b);
        logic [32:0] v;
        case (off)
            3'd0:         v = {30'd0, b[3:1]};
            3'd1, 3'd3:   v = {r[24:0], b};
            default:      v = {r[25:0], b[7:1]};
        endcase
        return v;
    endfunction

    function automatic t_result make_result(input t_state s, input logic [2:0] st);
        t_result res;
        res.status         = st;
        res.pes_sid        = s.pes_sid;
        res.packet_length  = s.length;
        res.header_flags   = s.flags;
        res.pts            = s.pts;
        if (s.flags[6]) begin
            res.dts = s.dts;
        end else if (s.flags[7]) begin
            res.dts = s.pts;
        end else begin
            res.dts = '0;
        end
        res.ref_clk_base   = s.ref_clk_base;
        res.ref_clk_ext    = s.ref_clk_ext;
        res.es_rate        = s.rate;
        res.trick_and_copy = s.trick_copy;
        res.previous_crc   = s.crc;
        res.header_size    = {1'b0, s.header_len} + HEADER_FIXED;
        return res;
    endfunction

endpackage

/* rtl/pes_header_parser_unit.sv */
// PES header parser.
// The slave side takes one word per packet byte: tdata carries the byte and
// tuser marks the first byte of a PES packet. Bytes seen outside an open
// header are taken and dropped.
// The master side gives one word per parsed header: tuser carries the status
// (ok, bad start code, bad flag marker, bad timestamp marker, truncated) and
// tdata the collected fields. A header is closed by its last announced
// optional field (by the header length byte when none is announced), by an
// error, or by a new first byte, which also opens the next packet.
// Throughput is one byte per cycle while tready is high; each byte passes a
// single stage of field shifting against a byte position counter. The result
// word is registered into the output word, or into the second buffer word while the receiver stalls.
// Reset clears the parser state and empties the output buffer, so the
// parser waits for a first byte.
// The output buffer holds two words. While the receiver stalls, bytes are
// still taken until the second word is occupied; tready then stays low until
// the receiver takes a word.
module pes_header_parser_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // byte_in[7:0]
    input  logic [7:0]                     i_s_tdata,
    // first[0]
    input  logic                           i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // pes_sid[7:0], packet_length[23:8], header_flags[37:24], pts[70:38],
    // dts[103:71], ref_clk_base[136:104], ref_clk_ext[145:137],
    // es_rate[167:146], trick_and_copy[177:168], previous_crc[193:178],
    // header_size[202:194], zero fill above
    output logic [php_pkg::DATA_W-1:0]     o_m_tdata,
    // status[2:0]
    output logic [php_pkg::STATUS_W-1:0]   o_m_tuser
);

    php_pkg::t_state  r_st;
    php_pkg::t_state  n_st;
    php_pkg::t_result w_res;
    php_pkg::t_result r_out;
    php_pkg::t_result r_skid;
    php_pkg::t_loc    w_loc;
    logic             r_out_valid;
    logic             r_skid_valid;
    logic             w_accept;
    logic             w_trunc;
    logic             w_emit;
    logic             w_push;
    logic [2:0]       w_status;
    logic [5:0]       w_p;
    logic [7:0]       w_b;

    assign o_s_tready = !r_skid_valid;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_b        = i_s_tdata;

    always_comb begin
        n_st     = r_st;
        w_trunc  = 1'b0;
        w_emit   = 1'b0;
        w_status = php_pkg::ST_OK;
        w_p      = r_st.pos;
        w_loc    = php_pkg::locate(r_st.pos, r_st.flags[7:0]);
        if (w_accept) begin
            if (i_s_tuser) begin
                w_trunc     = r_st.active;
                n_st        = '0;
                n_st.active = 1'b1;
            end
            w_p   = n_st.pos;
            w_loc = php_pkg::locate(n_st.pos, n_st.flags[7:0]);
            if (n_st.active) begin
                n_st.pos = w_p + 6'd1;
                case (w_p)
                    php_pkg::POS_SC0, php_pkg::POS_SC1: begin
                        if (w_b != 8'h00) begin
                            n_st.sc_err = 1'b1;
                        end
                    end
                    php_pkg::POS_SC2: begin
                        if (w_b != 8'h01 || n_st.sc_err) begin
                            w_emit      = 1'b1;
                            w_status    = php_pkg::ST_BAD_START;
                            n_st.active = 1'b0;
                        end
                    end
                    php_pkg::POS_ID: begin
                        n_st.pes_sid = w_b;
                    end
                    php_pkg::POS_LEN_HI: begin
                        n_st.length = {w_b, 8'h00};
                    end
                    php_pkg::POS_LEN_LO: begin
                        n_st.length = {n_st.length[15:8], w_b};
                    end
                    php_pkg::POS_FLAG1: begin
                        n_st.flags = {w_b[5:0], 8'h00};
                        if (w_b[7:6] != 2'b10) begin
                            w_emit      = 1'b1;
                            w_status    = php_pkg::ST_BAD_MARKER;
                            n_st.active = 1'b0;
                        end
                    end
                    php_pkg::POS_FLAG2: begin
                        n_st.flags = {n_st.flags[13:8], w_b};
                    end
                    php_pkg::POS_HLEN: begin
                        n_st.header_len = w_b;
                        if (w_loc.last == php_pkg::POS_OPT) begin
                            w_emit      = 1'b1;
                            n_st.active = 1'b0;
                        end
                    end
                    default: begin
                        case (w_loc.id)
                            php_pkg::FLD_PTS: begin
                                if (w_loc.off == 3'd0 && !w_b[5]) begin
                                    w_emit   = 1'b1;
                                    w_status = php_pkg::ST_BAD_TS;
                                end else begin
                                    n_st.pts = php_pkg::ts_shift(n_st.pts, w_loc.off, w_b);
                                end
                            end
                            php_pkg::FLD_DTS: begin
                                if (w_loc.off == 3'd0 && !w_b[4]) begin
                                    w_emit   = 1'b1;
                                    w_status = php_pkg::ST_BAD_TS;
                                end else begin
                                    n_st.dts = php_pkg::ts_shift(n_st.dts, w_loc.off, w_b);
                                end
                            end
                            php_pkg::FLD_ESCR: begin
                                case (w_loc.off)
                                    3'd0: n_st.ref_clk_base = {28'd0, w_b[5:3], w_b[1:0]};
                                    3'd1: n_st.ref_clk_base = {n_st.ref_clk_base[24:0], w_b};
                                    3'd2: n_st.ref_clk_base = {n_st.ref_clk_base[25:0],
                                                               w_b[7:3], w_b[1:0]};
                                    3'd3: n_st.ref_clk_base = {n_st.ref_clk_base[24:0], w_b};
                                    3'd4: begin
                                        n_st.ref_clk_base = {n_st.ref_clk_base[27:0],
                                                             w_b[7:3]};
                                        n_st.ref_clk_ext  = {w_b[1:0], 7'd0};
                                    end
                                    default: n_st.ref_clk_ext = n_st.ref_clk_ext |
                                                                {2'd0, w_b[7:1]};
                                endcase
                            end
                            php_pkg::FLD_RATE: begin
                                case (w_loc.off)
                                    3'd0:    n_st.rate = {15'd0, w_b[6:0]};
                                    3'd1:    n_st.rate = {n_st.rate[13:0], w_b};
                                    default: n_st.rate = {n_st.rate[14:0], w_b[7:1]};
                                endcase
                            end
                            php_pkg::FLD_TRICK: begin
                                n_st.trick_copy = {w_b[7:5], n_st.trick_copy[6:0]};
                            end
                            php_pkg::FLD_COPY: begin
                                n_st.trick_copy = {n_st.trick_copy[9:7], w_b[6:0]};
                            end
                            php_pkg::FLD_CRC: begin
                                if (w_loc.off == 3'd0) begin
                                    n_st.crc = {w_b, 8'h00};
                                end else begin
                                    n_st.crc = {n_st.crc[15:8], w_b};
                                end
                            end
                            default: begin
                                n_st.active = 1'b0;
                            end
                        endcase
                        if (w_loc.id != php_pkg::FLD_NONE &&
                            (w_emit || w_p + 6'd1 == w_loc.last)) begin
                            w_emit      = 1'b1;
                            n_st.active = 1'b0;
                        end
                    end
                endcase
            end
        end
        w_push = w_trunc || w_emit;
        w_res  = w_trunc ? php_pkg::make_result(r_st, php_pkg::ST_TRUNC)
                         : php_pkg::make_result(n_st, w_status);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (w_accept) begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_m_tready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= w_push;
            end
        end else if (w_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_m_tready) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (w_push) begin
                r_out <= w_res;
            end
        end else if (w_push) begin
            r_skid <= w_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.status;
    assign o_m_tdata  = {5'd0, r_out.header_size, r_out.previous_crc, r_out.trick_and_copy,
                         r_out.es_rate, r_out.ref_clk_ext, r_out.ref_clk_base, r_out.dts,
                         r_out.pts, r_out.header_flags, r_out.packet_length,
                         r_out.pes_sid};

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("second output word held while the first is empty");

    a_pos_in_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.active |-> r_st.pos <= 6'd31)
        else $error("byte position ran past the longest header");

    a_start_err_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && w_res.status == php_pkg::ST_BAD_START) |-> (w_p == php_pkg::POS_SC2))
        else $error("start code error reported away from the third byte");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tuser <= php_pkg::ST_TRUNC)
        else $error("status code out of range");

endmodule
